// ----- rtl/core/dps_pkg.sv -----
// ----------------------------------------------------------------------------
// dps_pkg: shared types and constants of the descale phase sequencer
// Phase codes, register indexes, configuration and result records.
// ----------------------------------------------------------------------------
package dps_pkg;

    // Width of the phase timer
    localparam int TIMER_BITS = 21;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
    // Compare width that holds both the timer and the widest period register
    localparam int PERIOD_W = 20;
    localparam int CMP_W = (TIMER_BITS > PERIOD_W) ? TIMER_BITS : PERIOD_W;

    localparam int CYCLE_W = 7;
    localparam int BEAT_W  = 11;
    localparam int STEP_W  = 3;
    localparam int POPUP_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [7:0]         SOAK_LEVEL  = 8'd10;
    localparam logic [7:0]         PULSE_LEVEL = 8'd30;
    localparam logic [STEP_W-1:0]  BEAT_STEPS  = 3'd5;
    localparam logic [CYCLE_W-1:0] CYCLE_SAT   = 7'd127;
    localparam logic [BEAT_W-1:0]  BEAT_SAT    = 11'd2047;

    localparam logic [PERIOD_W-1:0] SOAK_RESET  = 20'd10000;
    localparam logic [PERIOD_W-1:0] REST_RESET  = 20'd120000;
    localparam logic [PERIOD_W-1:0] PULSE_RESET = 20'd4000;
    localparam logic [CYCLE_W-1:0]  LIMIT_RESET = 7'd100;
    localparam logic [BEAT_W-1:0]   CLOSED_RESET = 11'd1000;
    localparam logic [BEAT_W-1:0]   OPEN_RESET   = 11'd200;
    localparam logic [POPUP_W-1:0]  POPUP_RESET  = 16'd1000;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_SOAK  = 3'd1,
        PH_REST  = 3'd2,
        PH_PULSE = 3'd3,
        PH_BEAT  = 3'd4,
        PH_FIN   = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        PUMP_OFF  = 2'd0,
        PUMP_RAW  = 2'd1,
        PUMP_FULL = 2'd2
    } pump_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SOAK   = 3'd0,
        REG_REST   = 3'd1,
        REG_PULSE  = 3'd2,
        REG_LIMIT  = 3'd3,
        REG_CLOSED = 3'd4,
        REG_OPEN   = 3'd5,
        REG_POPUP  = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] soak_period_ms;
        logic [PERIOD_W-1:0] rest_period_ms;
        logic [PERIOD_W-1:0] pulse_period_ms;
        logic [CYCLE_W-1:0]  cycle_limit;
        logic [BEAT_W-1:0]   beat_closed_ms;
        logic [BEAT_W-1:0]   beat_open_ms;
        logic [POPUP_W-1:0]  popup_period_ms;
    } cfg_t;

    // Declared from the highest bit down: pump_mode lands in bits 1:0
    typedef struct packed {
        logic [2:0]         phase_now;
        logic               popup_pulse;
        logic [CYCLE_W-1:0] cycle_shown;
        logic               cycle_update;
        logic               start_pulse;
        logic               steam_relay_on;
        logic               valve_open;
        logic [7:0]         pump_level;
        logic [1:0]         pump_mode;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

endpackage

// ----- rtl/core/dps_cfg.sv -----
// ----------------------------------------------------------------------------
// dps_cfg: configuration register file
// Seven timing and limit registers written through a valid/ready channel.
// ----------------------------------------------------------------------------
module dps_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dps_pkg::CFG_DATA_W-1:0]   cfg_data,
    output dps_pkg::cfg_t                    cfg
);
    import dps_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.soak_period_ms  <= SOAK_RESET;
            cfg_reg.rest_period_ms  <= REST_RESET;
            cfg_reg.pulse_period_ms <= PULSE_RESET;
            cfg_reg.cycle_limit     <= LIMIT_RESET;
            cfg_reg.beat_closed_ms  <= CLOSED_RESET;
            cfg_reg.beat_open_ms    <= OPEN_RESET;
            cfg_reg.popup_period_ms <= POPUP_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SOAK:   cfg_reg.soak_period_ms  <= cfg_data;
                REG_REST:   cfg_reg.rest_period_ms  <= cfg_data;
                REG_PULSE:  cfg_reg.pulse_period_ms <= cfg_data;
                REG_LIMIT:  cfg_reg.cycle_limit     <= cfg_data[CYCLE_W-1:0];
                REG_CLOSED: cfg_reg.beat_closed_ms  <= cfg_data[BEAT_W-1:0];
                REG_OPEN:   cfg_reg.beat_open_ms    <= cfg_data[BEAT_W-1:0];
                REG_POPUP:  cfg_reg.popup_period_ms <= cfg_data[POPUP_W-1:0];
                default:    ;
            endcase
        end
    end

endmodule

// ----- rtl/core/dps_in_stage.sv -----
// ----------------------------------------------------------------------------
// dps_in_stage: input register
// Captures one tick transfer and holds it until the core consumes it.
// ----------------------------------------------------------------------------
module dps_in_stage (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic brew_switch,
    input  logic advance,
    output logic in_valid,
    output logic in_switch
);
    logic valid_reg;
    logic switch_reg;

    // Free slot, or the held tick moves on in this cycle
    assign s_tready  = !valid_reg || advance;
    assign in_valid  = valid_reg;
    assign in_switch = switch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            switch_reg <= brew_switch;
        end
    end

endmodule

// ----- rtl/core/dps_core.sv -----
// ----------------------------------------------------------------------------
// dps_core: phase state machine and actuator state
// Advances the sequencer by one tick whenever step_en is high.
// ----------------------------------------------------------------------------
module dps_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  logic              brew_switch,
    input  dps_pkg::cfg_t     cfg,
    output dps_pkg::result_t  result
);
    import dps_pkg::*;

    phase_t                phase_reg, phase_next;
    logic [TIMER_BITS-1:0] elapsed_reg, elapsed_next;
    logic [CYCLE_W-1:0]    count_reg, count_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [BEAT_W-1:0]     beat_el_reg, beat_el_next;
    logic [1:0]            mode_reg, mode_next;
    logic [7:0]            level_reg, level_next;
    logic                  valve_reg, valve_next;
    logic                  relay_reg, relay_next;

    logic [TIMER_BITS-1:0] elapsed_inc;
    logic [CMP_W-1:0]      elapsed_cmp;
    logic                  soak_done, rest_done, pulse_done, popup_done;
    logic [CYCLE_W-1:0]    count_inc;
    logic                  under_limit;
    logic [BEAT_W-1:0]     beat_el_inc;
    logic [BEAT_W-1:0]     beat_dur;
    logic                  beat_step_done;
    logic [STEP_W-1:0]     step_inc;
    logic                  beat_over;
    logic                  held;

    assign held = brew_switch;

    // Phase timer saturates and stands still in idle
    assign elapsed_inc = (phase_reg != PH_IDLE && elapsed_reg != TIMER_MAX)
                         ? elapsed_reg + 1'b1 : elapsed_reg;
    assign elapsed_cmp = CMP_W'(elapsed_inc);
    assign soak_done   = elapsed_cmp > CMP_W'(cfg.soak_period_ms);
    assign rest_done   = elapsed_cmp > CMP_W'(cfg.rest_period_ms);
    assign pulse_done  = elapsed_cmp > CMP_W'(cfg.pulse_period_ms);
    assign popup_done  = elapsed_cmp > CMP_W'(cfg.popup_period_ms);

    assign count_inc   = (count_reg < CYCLE_SAT) ? count_reg + 1'b1 : count_reg;
    assign under_limit = count_inc < cfg.cycle_limit;

    assign beat_el_inc    = (beat_el_reg < BEAT_SAT) ? beat_el_reg + 1'b1 : beat_el_reg;
    assign beat_dur       = step_reg[0] ? cfg.beat_open_ms : cfg.beat_closed_ms;
    assign beat_step_done = beat_el_inc >= beat_dur;
    assign step_inc       = step_reg + 1'b1;
    assign beat_over      = step_inc >= BEAT_STEPS;

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (held)
                    phase_next = PH_SOAK;
            end
            PH_SOAK:
            begin
                if (soak_done)
                    phase_next = under_limit ? PH_REST : PH_FIN;
                else if (!held)
                    phase_next = PH_FIN;
            end
            PH_REST:
            begin
                if (rest_done)
                    phase_next = PH_PULSE;
                else if (!held)
                    phase_next = PH_FIN;
            end
            PH_PULSE:
            begin
                if (pulse_done)
                    phase_next = PH_BEAT;
                else if (!held)
                    phase_next = PH_FIN;
            end
            PH_BEAT:
            begin
                // switch ignored during the valve beat
                if (beat_step_done && beat_over)
                    phase_next = under_limit ? PH_SOAK : PH_FIN;
            end
            default:
            begin
                phase_next = held ? PH_FIN : PH_IDLE;
            end
        endcase
    end

    // Counters, actuators and per-tick pulses
    always_comb
    begin
        elapsed_next = elapsed_inc;
        count_next   = count_reg;
        step_next    = step_reg;
        beat_el_next = beat_el_reg;
        mode_next    = mode_reg;
        level_next   = level_reg;
        valve_next   = valve_reg;
        relay_next   = relay_reg;
        result       = '0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (held)
                begin
                    result.start_pulse = 1'b1;
                    valve_next   = 1'b1;
                    relay_next   = 1'b1;
                    count_next   = '0;
                    elapsed_next = '0;
                end
            end
            PH_SOAK:
            begin
                mode_next  = PUMP_RAW;
                level_next = SOAK_LEVEL;
                if (soak_done)
                begin
                    result.cycle_update = 1'b1;
                    result.cycle_shown  = count_reg;
                    count_next = count_inc;
                    if (under_limit)
                        elapsed_next = '0;
                end
            end
            PH_REST:
            begin
                mode_next = PUMP_OFF;
                if (rest_done)
                begin
                    result.cycle_update = 1'b1;
                    result.cycle_shown  = count_reg;
                    count_next   = count_inc;
                    elapsed_next = '0;
                end
            end
            PH_PULSE:
            begin
                mode_next  = PUMP_RAW;
                level_next = PULSE_LEVEL;
                if (pulse_done)
                begin
                    mode_next    = PUMP_FULL;
                    valve_next   = 1'b0;
                    step_next    = '0;
                    beat_el_next = '0;
                end
            end
            PH_BEAT:
            begin
                beat_el_next = beat_el_inc;
                if (beat_step_done)
                begin
                    beat_el_next = '0;
                    if (beat_over)
                    begin
                        step_next  = '0;
                        valve_next = 1'b1;
                        mode_next  = PUMP_OFF;
                        result.cycle_update = 1'b1;
                        result.cycle_shown  = count_reg;
                        count_next = count_inc;
                        if (under_limit)
                            elapsed_next = '0;
                    end
                    else
                    begin
                        step_next  = step_inc;
                        valve_next = step_inc[0];
                    end
                end
            end
            default:
            begin
                mode_next  = PUMP_OFF;
                valve_next = 1'b0;
                relay_next = 1'b0;
                if (popup_done)
                begin
                    result.popup_pulse = 1'b1;
                    elapsed_next = '0;
                end
            end
        endcase
        result.pump_mode      = mode_next;
        result.pump_level     = level_next;
        result.valve_open     = valve_next;
        result.steam_relay_on = relay_next;
        result.phase_now      = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            elapsed_reg <= '0;
            count_reg   <= '0;
            step_reg    <= '0;
            beat_el_reg <= '0;
            mode_reg    <= PUMP_OFF;
            level_reg   <= '0;
            valve_reg   <= 1'b0;
            relay_reg   <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            count_reg   <= count_next;
            step_reg    <= step_next;
            beat_el_reg <= beat_el_next;
            mode_reg    <= mode_next;
            level_reg   <= level_next;
            valve_reg   <= valve_next;
            relay_reg   <= relay_next;
        end
    end

endmodule

// ----- rtl/core/dps_out_stage.sv -----
// ----------------------------------------------------------------------------
// dps_out_stage: result register
// Holds one result transfer until the receiver takes it.
// ----------------------------------------------------------------------------
module dps_out_stage (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  dps_pkg::result_t                    result,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata, from bit 0: pump_mode[1:0], pump_level[9:2], valve_open[10],
    // steam_relay_on[11], start_pulse[12], cycle_update[13],
    // cycle_shown[20:14], popup_pulse[21], phase_now[24:22], zero fill
    output logic [dps_pkg::TDATA_W-1:0]         m_tdata
);
    import dps_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    assign m_tvalid = valid_reg;
    assign m_tdata  = TDATA_W'(result_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

endmodule

// ----- rtl/core/descale_phase_sequencer.sv -----
// ----------------------------------------------------------------------------
// descale_phase_sequencer: descale phase sequencer top level
// One input transfer per millisecond tick carrying the brew switch; one
// result transfer per tick with pump, valve, relay, pulses and phase.
// ----------------------------------------------------------------------------
// Usage:
//   s_tvalid/s_tready/s_tdata: tick input, s_tdata[0] = brew_switch.
//   m_tvalid/m_tready/m_tdata: one result per tick, the state after it.
//   cfg_valid/cfg_ready/cfg_index/cfg_data: register writes, index 0..6 =
//     soak, rest, pulse periods, cycle limit, beat closed, beat open, popup
//     period; cfg_ready is always high. Write only while no tick is pending.
// Path: a tick accepted into the input register moves through the core into
//   the result register, which raises m_tvalid with its result, as soon as
//   that register is free or its result is being taken.
// Throughput: one tick per cycle while m_tready stays high; the core computes
//   each state update combinationally between the input and result registers.
// Reset: phase idle, timers and cycle count zero, pump off, valve closed,
//   relay off, registers at their default values, both channels empty.
// Stall: while m_tready is low the result register holds, the input register
//   takes one more tick, and then s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module descale_phase_sequencer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata, from bit 0: brew_switch[0], zero fill
    input  logic [7:0]                       s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata, from bit 0: pump_mode[1:0], pump_level[9:2], valve_open[10],
    // steam_relay_on[11], start_pulse[12], cycle_update[13],
    // cycle_shown[20:14], popup_pulse[21], phase_now[24:22], zero fill
    output logic [dps_pkg::TDATA_W-1:0]      m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dps_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import dps_pkg::*;

    cfg_t    cfg;
    result_t result;
    logic    in_valid;
    logic    in_switch;
    logic    advance;

    // Move the held tick into the result register when that slot frees up
    assign advance = in_valid && (!m_tvalid || m_tready);

    dps_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dps_in_stage u_in (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .brew_switch (s_tdata[0]),
        .advance     (advance),
        .in_valid    (in_valid),
        .in_switch   (in_switch)
    );

    dps_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (advance),
        .brew_switch (in_switch),
        .cfg         (cfg),
        .result      (result)
    );

    dps_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .result   (result),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
